[hw/rtl/neighbour_set_change_detector_unit_macros.svh]
// assertion helpers for the checker file
// each macro samples on clk and is disabled while rst is high
`ifndef NEIGHBOUR_SET_CHANGE_DETECTOR_UNIT_MACROS_SVH
`define NEIGHBOUR_SET_CHANGE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define NSCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NSCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/nscd_pkg.sv]
// ---------------------------------------------------------------------------
// nscd_pkg
// shared types and constants of the neighbour set change detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nscd_pkg;

  localparam int THR_W      = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd16384;
  localparam int Q16_SHIFT  = 16;
  localparam int OUT_CNT_W  = 6;
  localparam int OUT_DATA_W = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;

  // per-item control broadcast along the cell row
  typedef struct packed {
    logic probe;   // compare incoming address against stored entry
    logic shift;   // move pending addresses one cell down the row
    logic adopt;   // copy pending address into stored entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/nscd_cell.sv]
// ---------------------------------------------------------------------------
// nscd_cell
// one slot of the neighbour row: a stored and a pending address
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nscd_cell #(
  parameter int ADDR_BITS = 48,
  parameter int CNT_W     = 6,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire nscd_pkg::cell_ctrl_t ctrl,
  input  wire logic [ADDR_BITS-1:0] probe_addr,
  input  wire logic [ADDR_BITS-1:0] pend_in,
  input  wire logic [CNT_W-1:0]     stored_count,
  output logic      [ADDR_BITS-1:0] pend_addr,
  output logic                      hit
);

  logic [ADDR_BITS-1:0] stored_addr;
  logic [ADDR_BITS-1:0] pend_addr_next;
  logic                 stored_live;

  // slot holds a member of the set when it lies below the stored count
  assign stored_live    = stored_count > CNT_W'(INDEX);
  assign pend_addr_next = ctrl.shift ? pend_in : pend_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= ctrl.probe && stored_live && (stored_addr == probe_addr);
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    if (ctrl.adopt) begin
      stored_addr <= pend_addr_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/nscd_eval.sv]
// ---------------------------------------------------------------------------
// nscd_eval
// significance test by cross multiplication and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nscd_eval #(
  parameter int CNT_W = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  input  wire logic [CNT_W-1:0]                   req_size,
  input  wire logic [CNT_W-1:0]                   req_common,
  input  wire logic                               req_ovf,
  input  wire logic [nscd_pkg::THR_W-1:0]         threshold,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [nscd_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic      [nscd_pkg::OUT_USER_W-1:0]    m_tuser
);

  localparam int PROD_W = nscd_pkg::THR_W + CNT_W;

  logic [CNT_W-1:0]  fresh;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              sig;

  // new-node count, floored at zero
  assign fresh = (req_size > req_common) ? (req_size - req_common) : '0;
  assign lhs   = PROD_W'(fresh) << nscd_pkg::Q16_SHIFT;
  assign rhs   = PROD_W'(threshold) * PROD_W'(req_size);
  assign sig   = (fresh != '0) && (lhs >= rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (req_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      m_tdata <= {(nscd_pkg::OUT_DATA_W - 2 * nscd_pkg::OUT_CNT_W)'(0),
                  nscd_pkg::OUT_CNT_W'(req_common),
                  nscd_pkg::OUT_CNT_W'(req_size)};
      m_tuser <= {req_ovf, sig};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/neighbour_set_change_detector_unit.sv]
// ---------------------------------------------------------------------------
// neighbour_set_change_detector_unit
// matches a new neighbour list against the stored set and flags big changes
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  s_axis   | in  | s_tvalid / s_tready  | tdata node_address, tlast
//           |     |                      | last_in_list, tuser entry / adopt
//  m_axis   | out | m_tvalid / m_tready  | tdata sizes, tuser significant/ovf
//  cfg      | in  | cfg_valid/cfg_ready  | cfg_data change_threshold_q16
//
//  list items that are not last are taken one per cycle
//  a last item passes three register stages (row, match count, test) before its
//  result shows; input stays closed from the last item until that result is taken
//  rst is synchronous; it empties both sets and restores the threshold to 0.25
//  the config port is always ready
//
`timescale 1ns / 1ps
`default_nettype none

module neighbour_set_change_detector_unit #(
  parameter int MAX_NEIGHBOURS = 32,
  parameter int ADDR_BITS      = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // s_tdata: node_address
  input  wire logic [((ADDR_BITS + 7) / 8) * 8-1:0]  s_tdata,
  // s_tuser: carries_entry, adopt_list
  input  wire logic [nscd_pkg::IN_USER_W-1:0]        s_tuser,
  input  wire logic                                  s_tlast,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // m_tdata: new_list_size, common_count, zero fill
  output logic      [nscd_pkg::OUT_DATA_W-1:0]       m_tdata,
  // m_tuser: significant, list_overflow
  output logic      [nscd_pkg::OUT_USER_W-1:0]       m_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  input  wire logic [nscd_pkg::THR_W-1:0]            cfg_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready
);

  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

  // threshold register
  logic [nscd_pkg::THR_W-1:0] threshold;

  // list front end
  logic             accept;
  logic             take;
  logic             drop;
  logic             room;
  logic [CNT_W-1:0] pend_count;
  logic [CNT_W-1:0] pend_count_next;
  logic [CNT_W-1:0] stored_count;
  logic             ovf;
  logic             busy;

  // row of cells
  nscd_pkg::cell_ctrl_t ctrl;
  logic [ADDR_BITS-1:0] probe_addr;
  logic [ADDR_BITS-1:0] pend_addr [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0] hit;

  // stage after the row: last item bookkeeping
  logic             a_last;
  logic [CNT_W-1:0] a_size;
  logic             a_ovf;

  // match accumulation and request to the test stage
  logic [CNT_W-1:0] match_count;
  logic [CNT_W-1:0] match_sum;
  logic             b_valid;
  logic [CNT_W-1:0] b_size;
  logic [CNT_W-1:0] b_common;
  logic             b_ovf;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= nscd_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // closed from a last item until its result leaves
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign room     = pend_count < CNT_W'(MAX_NEIGHBOURS);
  assign take     = accept && s_tuser[0] && room;
  assign drop     = accept && s_tuser[0] && !room;
  assign pend_count_next = pend_count + CNT_W'(take);

  assign probe_addr = s_tdata[ADDR_BITS-1:0];

  always_comb begin
    ctrl       = '0;
    ctrl.probe = take;
    ctrl.shift = take;
    ctrl.adopt = accept && s_tlast && s_tuser[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count   <= '0;
      stored_count <= '0;
      ovf          <= 1'b0;
      busy         <= 1'b0;
      a_last       <= 1'b0;
    end else begin
      a_last <= accept && s_tlast;
      if (accept && s_tlast) begin
        // end of list: counters start over for the next one
        pend_count <= '0;
        ovf        <= 1'b0;
        busy       <= 1'b1;
        if (s_tuser[1]) begin
          stored_count <= pend_count_next;
        end
      end else begin
        pend_count <= pend_count_next;
        ovf        <= ovf || drop;
        if (m_tvalid && m_tready) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_size <= pend_count_next;
    a_ovf  <= ovf || drop;
  end

  // newest pending address sits in cell 0, older ones move down the row
  for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
    logic [ADDR_BITS-1:0] pend_in;
    if (i == 0) begin : g_head
      assign pend_in = probe_addr;
    end else begin : g_body
      assign pend_in = pend_addr[i-1];
    end
    nscd_cell #(
      .ADDR_BITS (ADDR_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .probe_addr   (probe_addr),
      .pend_in      (pend_in),
      .stored_count (stored_count),
      .pend_addr    (pend_addr[i]),
      .hit          (hit[i])
    );
  end

  // one match at most per item, even with duplicates in the stored set
  assign match_sum = match_count + CNT_W'(|hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
      b_valid     <= 1'b0;
    end else begin
      b_valid <= a_last;
      if (a_last) begin
        match_count <= '0;
      end else begin
        match_count <= match_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_size   <= a_size;
    b_common <= match_sum;
    b_ovf    <= a_ovf;
  end

  nscd_eval #(
    .CNT_W (CNT_W)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (b_valid),
    .req_size   (b_size),
    .req_common (b_common),
    .req_ovf    (b_ovf),
    .threshold  (threshold),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/nscd_checker.sv]
// ---------------------------------------------------------------------------
// nscd_checker
// port-level checks of the neighbour set change detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "neighbour_set_change_detector_unit_macros.svh"

module nscd_checker #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              s_tlast,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [nscd_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic [nscd_pkg::OUT_USER_W-1:0]   m_tuser
);

  // counts are not cut by the 6-bit fields
  localparam bit NO_WRAP = MAX_NEIGHBOURS < 64;

  logic [nscd_pkg::OUT_CNT_W-1:0] size_f;
  logic [nscd_pkg::OUT_CNT_W-1:0] common_f;
  logic                           sig_out;

  assign size_f   = m_tdata[nscd_pkg::OUT_CNT_W-1:0];
  assign common_f = m_tdata[2*nscd_pkg::OUT_CNT_W-1:nscd_pkg::OUT_CNT_W];
  assign sig_out  = m_tvalid && m_tuser[0];

  `NSCD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `NSCD_ASSERT_NXT(a_last_closes, s_tvalid && s_tready && s_tlast, !s_tready, "open after last")
  `NSCD_ASSERT_IMP(a_closed_on_result, m_tvalid, !s_tready, "input open while result waits")
  `NSCD_ASSERT_IMP(a_common_le_size, NO_WRAP && m_tvalid, common_f <= size_f, "common above size")
  `NSCD_ASSERT_IMP(a_sig_has_new, NO_WRAP && sig_out, common_f < size_f, "sig without new")

endmodule

bind neighbour_set_change_detector_unit nscd_checker #(
  .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
) u_nscd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[dv/neighbour_set_change_detector_unit_test.sv]
// ---------------------------------------------------------------------------
// neighbour_set_change_detector_unit_test
// self-checking bench for the neighbour set change detector
// ---------------------------------------------------------------------------
// neighbour lists go in one address per item on the slave stream. A bench-side
// copy of the stored set and the threshold predicts the change report of each
// list, and the reports on the master stream are checked in order. A short
// table of directed lists comes first, then random lists over several
// threshold settings and stall mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbour_set_change_detector_unit_test;

  localparam int ADDR_W  = 48;
  localparam int NBR_MAX = 32;
  localparam int CNT_W   = nscd_pkg::OUT_CNT_W;
  localparam int THR_W   = nscd_pkg::THR_W;
  localparam int PHASES  = 6;
  localparam int PHASE_ITEMS = 285;

  // one change report, as the block puts it out
  typedef struct packed {
    logic             significant;
    logic [CNT_W-1:0] list_size;
    logic [CNT_W-1:0] common;
    logic             overflow;
  } change_report_t;

  localparam change_report_t NO_REPORT = '0;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed row: an item of a list, or a threshold write (value in addr)
  typedef struct {
    row_kind_t      kind;
    logic [47:0]    addr;
    bit             entry;
    bit             last;
    bit             adopt;
    bit             typed;
    change_report_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [47:0]       s_tdata  = '0;
  logic [1:0]        s_tuser  = '0;
  logic              s_tlast  = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [THR_W-1:0]  cfg_data  = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;

  neighbour_set_change_detector_unit #(
    .MAX_NEIGHBOURS(NBR_MAX),
    .ADDR_BITS(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),     // node_address
    .s_tuser(s_tuser),     // carries_entry, adopt_list
    .s_tlast(s_tlast),     // last_in_list
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),     // new_list_size, common_count, zero fill
    .m_tuser(m_tuser),     // significant, list_overflow
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the block state
  logic [47:0]      prev_set [NBR_MAX];
  int               prev_cnt = 0;
  logic [47:0]      new_set [NBR_MAX];
  int               new_cnt = 0;
  int               hit_cnt = 0;
  bit               ovf_seen = 1'b0;
  logic [THR_W-1:0] thr_q16 = nscd_pkg::THR_RESET;

  change_report_t report_q [$];
  int             fault_count = 0;
  int             mismatch_count = 0;
  idle_mode_t     idle_mode = IDLE_NONE;
  int             phase_no = -1;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  logic [47:0]    addr_pool [10];

  // folds one accepted item into the pending list; on the last item it
  // returns 1 with the change report and closes the list
  function automatic bit track_list_item(input logic [47:0] addr, input bit entry,
                                         input bit last, input bit adopt,
                                         output change_report_t rep);
    bit hit;
    int fresh;
    longint unsigned lhs;
    longint unsigned rhs;
    rep = NO_REPORT;
    hit = 1'b0;
    if (entry) begin
      if (new_cnt < NBR_MAX) begin
        // a hit counts once even if the stored set holds the address twice
        for (int i = 0; i < prev_cnt; i++) begin
          if (prev_set[i] == addr) hit = 1'b1;
        end
        if (hit) hit_cnt++;
        new_set[new_cnt] = addr;
        new_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (!last) return 1'b0;
    fresh = (new_cnt > hit_cnt) ? new_cnt - hit_cnt : 0;
    // new/size >= thr/65536, cross-multiplied
    lhs = longint'(fresh) << nscd_pkg::Q16_SHIFT;
    rhs = longint'(thr_q16) * longint'(new_cnt);
    rep.significant = (fresh != 0) && (lhs >= rhs);
    rep.list_size   = CNT_W'(new_cnt);
    rep.common      = CNT_W'(hit_cnt);
    rep.overflow    = ovf_seen;
    if (adopt) begin
      for (int i = 0; i < new_cnt; i++) prev_set[i] = new_set[i];
      prev_cnt = new_cnt;
    end
    new_cnt  = 0;
    hit_cnt  = 0;
    ovf_seen = 1'b0;
    return 1'b1;
  endfunction

  // offers one item, waits for acceptance and books the expected report;
  // a typed expectation overrides the predicted one
  task automatic feed(input logic [47:0] addr, input bit entry, input bit last,
                      input bit adopt, input bit typed, input change_report_t want);
    int gap_pct;
    change_report_t rep;
    gap_pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= {adopt, entry};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (track_list_item(addr, entry, last, adopt, rep)) begin
      report_q.insert(report_q.size(), typed ? want : rep);
    end
  endtask

  // stops the input until every report is in, then lets the pipeline settle
  task automatic drain_reports();
    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_q16 = value;
    cfg_valid <= 1'b0;
  endtask

  // receiver: checks each accepted report, then decides tready for the next edge
  always @(posedge clk) begin
    change_report_t seen;
    change_report_t want;
    int stall_pct;
    if (!rst && m_tvalid && m_tready) begin
      seen.significant = m_tuser[0];
      seen.overflow    = m_tuser[1];
      seen.list_size   = m_tdata[CNT_W-1:0];
      seen.common      = m_tdata[2*CNT_W-1:CNT_W];
      if (report_q.size() == 0) begin
        fault_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report sig=%0d size=%0d common=%0d ovf=%0d",
                   seen.significant, seen.list_size, seen.common, seen.overflow);
      end else begin
        want = report_q[0];
        report_q.delete(0);
        if (seen !== want) begin
          fault_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch sig/size/common/ovf: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.significant, want.list_size, want.common, want.overflow,
                     seen.significant, seen.list_size, seen.common, seen.overflow);
        end
      end
    end
    stall_pct = (idle_mode == IDLE_RECV) ? 64 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (phase_no == 0 && !hold_done) begin
      // long hold-off while the sender keeps offering, so the input backs up
      hold_left <= 300;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // directed lists; typed results are the ones readable straight off the rules
  stim_row_t plan [0:20] = '{
    // empty list right after reset
    '{ROW_ITEM, 48'h0,              1'b0, 1'b1, 1'b0, 1'b1, '{1'b0, 6'd0, 6'd0, 1'b0}},
    // three extreme addresses, adopted as the first stored set
    '{ROW_ITEM, 48'h0,              1'b1, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h5555_5555_5555, 1'b1, 1'b1, 1'b1, 1'b1, '{1'b1, 6'd3, 6'd0, 1'b0}},
    // duplicate in the new list plus an item with no entry
    '{ROW_ITEM, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b1, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b0, NO_REPORT},
    // zero threshold: any new node is significant
    '{ROW_CFG,  48'h0,              1'b0, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h0,              1'b1, 1'b1, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h0000_0000_0001, 1'b1, 1'b1, 1'b0, 1'b0, NO_REPORT},
    // threshold above one: never significant
    '{ROW_CFG,  48'h1_FFFF,         1'b0, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h8000_0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, NO_REPORT},
    // threshold exactly one: only an all-new list passes
    '{ROW_CFG,  48'h1_0000,         1'b0, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h1234_5678_9ABC, 1'b1, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h0F0F_0F0F_0F0F, 1'b1, 1'b1, 1'b1, 1'b1, '{1'b1, 6'd2, 6'd0, 1'b0}},
    '{ROW_ITEM, 48'h0,              1'b1, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h1234_5678_9ABC, 1'b1, 1'b1, 1'b1, 1'b0, NO_REPORT},
    // back to the reset threshold, adopt an empty list
    '{ROW_CFG,  48'h4000,           1'b0, 1'b0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM, 48'h0,              1'b0, 1'b1, 1'b1, 1'b1, '{1'b0, 6'd0, 6'd0, 1'b0}},
    '{ROW_ITEM, 48'h0,              1'b1, 1'b1, 1'b0, 1'b0, NO_REPORT}
  };

  initial begin
    int budget;
    int len;
    int pick;
    bit last_has_entry;
    logic [47:0] addr;
    idle_mode_t mode_plan [PHASES];
    logic [THR_W-1:0] thr_plan [PHASES];

    mode_plan = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND};
    thr_plan  = '{17'd0, 17'd65535, 17'h1_FFFF, 17'h1_0000, 17'd0, 17'd1};
    thr_plan[4] = THR_W'($urandom_range(0, 131071));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_mode = IDLE_BOTH;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_reports();
        write_threshold(plan[i].addr[THR_W-1:0]);
      end else begin
        feed(plan[i].addr, plan[i].entry, plan[i].last, plan[i].adopt,
             plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reports();
      write_threshold(thr_plan[ph]);
      idle_mode = mode_plan[ph];
      phase_no  = ph;
      // small address pool so lists overlap the stored set
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int k = 2; k < 10; k++) addr_pool[k] = 48'({$urandom, $urandom});
      budget = 0;
      while (budget < PHASE_ITEMS) begin
        // mostly short lists, some long ones and a few at or past capacity
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(0, 8);
        else if (pick < 95) len = $urandom_range(9, 31);
        else len = $urandom_range(32, 40);
        last_has_entry = ($urandom_range(0, 99) < 70) && (len > 0);
        for (int j = 0; j < len - (last_has_entry ? 1 : 0); j++) begin
          if ($urandom_range(0, 9) == 0) begin
            // ignored item between entries
            feed(48'({$urandom, $urandom}), 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                 1'b0, NO_REPORT);
          end
          addr = ($urandom_range(0, 3) != 0) ? addr_pool[4'($urandom_range(0, 9))]
                                             : 48'({$urandom, $urandom});
          feed(addr, 1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'b0, NO_REPORT);
          budget++;
        end
        addr = ($urandom_range(0, 3) != 0) ? addr_pool[4'($urandom_range(0, 9))]
                                           : 48'({$urandom, $urandom});
        feed(addr, last_has_entry, 1'b1, 1'($urandom_range(0, 1)), 1'b0, NO_REPORT);
        budget++;
        // mid-phase pauses until the output side has caught up
        if (ph == 1 && budget >= PHASE_ITEMS / 2 && budget < PHASE_ITEMS / 2 + 42)
          drain_reports();
      end
    end

    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0 && report_q.size() == 0) begin
      $display("PASS neighbour_set_change_detector_unit");
    end else begin
      $display("FAIL neighbour_set_change_detector_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL neighbour_set_change_detector_unit");
    $finish;
  end

endmodule
